// ----- sv/stt_pkg.sv -----
// Shared types and constants for the search transposition table.
// Used by stt_front, stt_queue, stt_back and search_transposition_table.
`timescale 1ns / 1ps
`default_nettype none

package stt_pkg;

    // Entry count of the table; a power of two, so the low key bits form the index.
    localparam int TABLE_ENTRIES = 4096;
    localparam int IDX_W         = $clog2(TABLE_ENTRIES);

    // Depth of the queue between the front and the back.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam logic ACT_STORE = 1'b1;

    localparam logic [1:0] BND_EXACT = 2'd0;
    localparam logic [1:0] BND_LOWER = 2'd1;
    localparam logic [1:0] BND_UPPER = 2'd2;

    typedef enum logic [1:0] {
        OUT_CONTINUE = 2'd0,
        OUT_RETURN   = 2'd1,
        OUT_STORED   = 2'd2
    } t_outcome;

    typedef enum logic [1:0] {
        BK_CLEAR,
        BK_IDLE,
        BK_LOOKUP
    } t_back_state;

    typedef struct packed {
        logic               is_store;
        logic [IDX_W-1:0]   index;
        logic [63:0]        key;
        logic [5:0]         depth;
        logic signed [31:0] lo;
        logic signed [31:0] hi;
        logic signed [31:0] score;
        logic [1:0]         bound;
    } t_req;

    typedef struct packed {
        logic valid;
        t_req req;
    } t_slot;

    typedef struct packed {
        logic [63:0]        tag;
        logic signed [31:0] score;
        logic [5:0]         depth;
        logic [1:0]         bound;
    } t_entry;

endpackage

`default_nettype wire

// ----- sv/stt_front.sv -----
// Front end: accepts input items, classifies them as probe or store and
// hands them to the queue. Depends on stt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module stt_front (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_stall,
    input  wire logic                 i_action,
    input  wire logic [63:0]          i_pos_key,
    input  wire logic [5:0]           i_search_depth,
    input  wire logic signed [31:0]   i_window_low,
    input  wire logic signed [31:0]   i_window_high,
    input  wire logic signed [31:0]   i_store_score,
    input  wire logic [1:0]           i_store_bound,
    input  wire logic                 i_clearing,
    input  wire logic                 i_q_full,
    output stt_pkg::t_slot            o_push
);

    logic          r_valid;
    logic          n_valid;
    stt_pkg::t_req r_req;
    stt_pkg::t_req n_req;
    logic          accept;
    logic          push;

    assign o_in_stall = i_clearing || (r_valid && i_q_full);
    assign accept     = i_in_valid && !o_in_stall;
    assign push       = r_valid && !i_q_full;

    always_comb begin
        n_req.is_store = (i_action == stt_pkg::ACT_STORE);
        n_req.index    = i_pos_key[stt_pkg::IDX_W-1:0];
        n_req.key      = i_pos_key;
        n_req.depth    = i_search_depth;
        n_req.lo       = i_window_low;
        n_req.hi       = i_window_high;
        n_req.score    = i_store_score;
        n_req.bound    = i_store_bound;
    end

    always_comb begin
        if (accept) begin
            n_valid = 1'b1;
        end else if (push) begin
            n_valid = 1'b0;
        end else begin
            n_valid = r_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req <= n_req;
        end
    end

    assign o_push.valid = push;
    assign o_push.req   = r_req;

endmodule

`default_nettype wire

// ----- sv/stt_queue.sv -----
// Short FIFO of classified items between the front and the back.
// Depends on stt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module stt_queue (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire stt_pkg::t_slot  i_push,
    input  wire logic            i_pop,
    output stt_pkg::t_slot       o_head,
    output logic                 o_full
);

    stt_pkg::t_req                r_q [stt_pkg::QUEUE_DEPTH];
    logic [stt_pkg::QPTR_W-1:0]   r_wr_ptr;
    logic [stt_pkg::QPTR_W-1:0]   r_rd_ptr;
    logic [stt_pkg::QPTR_W:0]     r_count;
    logic                         do_push;
    logic                         do_pop;

    function automatic logic [stt_pkg::QPTR_W-1:0] next_ptr(
        input logic [stt_pkg::QPTR_W-1:0] ptr
    );
        if (ptr == stt_pkg::QPTR_W'(stt_pkg::QUEUE_DEPTH - 1)) begin
            return '0;
        end
        return ptr + 1'b1;
    endfunction

    assign o_full       = (r_count == (stt_pkg::QPTR_W + 1)'(stt_pkg::QUEUE_DEPTH));
    assign o_head.valid = (r_count != '0);
    assign o_head.req   = r_q[r_rd_ptr];
    assign do_push      = i_push.valid && !o_full;
    assign do_pop       = i_pop && o_head.valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= next_ptr(r_wr_ptr);
            end
            if (do_pop) begin
                r_rd_ptr <= next_ptr(r_rd_ptr);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_q[r_wr_ptr] <= i_push.req;
        end
    end

endmodule

`default_nettype wire

// ----- sv/stt_back.sv -----
// Back end: holds the table memory, clears it after reset, carries out
// probes and stores, and keeps the output register. Depends on stt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module stt_back (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire stt_pkg::t_slot       i_head,
    output logic                      o_pop,
    output logic                      o_clearing,
    output logic                      o_out_valid,
    input  wire logic                 i_out_stall,
    output logic [1:0]                o_outcome,
    output logic signed [31:0]        o_found_score,
    output logic signed [31:0]        o_new_low,
    output logic signed [31:0]        o_new_high
);

    localparam logic [stt_pkg::IDX_W-1:0] LAST_ADDR =
        stt_pkg::IDX_W'(stt_pkg::TABLE_ENTRIES - 1);

    stt_pkg::t_entry      r_table [stt_pkg::TABLE_ENTRIES];
    stt_pkg::t_entry      r_rd_data;
    stt_pkg::t_req        r_cur;
    stt_pkg::t_back_state r_state;
    stt_pkg::t_back_state n_state;
    logic [stt_pkg::IDX_W-1:0] r_clr_addr;

    logic                 r_out_valid;
    stt_pkg::t_outcome    r_out_outcome;
    logic signed [31:0]   r_out_found;
    logic signed [31:0]   r_out_low;
    logic signed [31:0]   r_out_high;

    stt_pkg::t_outcome    n_out_outcome;
    logic signed [31:0]   n_out_found;
    logic signed [31:0]   n_out_low;
    logic signed [31:0]   n_out_high;
    logic                 out_load;
    logic                 out_free;

    logic                      mem_we;
    logic [stt_pkg::IDX_W-1:0] mem_waddr;
    stt_pkg::t_entry           mem_wdata;
    logic                      rd_en;

    logic                 hit;
    logic signed [31:0]   ev_low;
    logic signed [31:0]   ev_high;
    stt_pkg::t_outcome    ev_outcome;
    logic signed [31:0]   ev_found;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign o_clearing = (r_state == stt_pkg::BK_CLEAR);

    // Probe evaluation on the registered table read.
    always_comb begin
        hit        = (r_rd_data.tag == r_cur.key) && (r_rd_data.depth >= r_cur.depth);
        ev_low     = r_cur.lo;
        ev_high    = r_cur.hi;
        ev_outcome = stt_pkg::OUT_CONTINUE;
        ev_found   = '0;
        if (hit) begin
            if (r_rd_data.bound == stt_pkg::BND_EXACT) begin
                ev_outcome = stt_pkg::OUT_RETURN;
                ev_found   = r_rd_data.score;
            end else begin
                if (r_rd_data.bound == stt_pkg::BND_LOWER
                        && $signed(r_rd_data.score) > $signed(r_cur.lo)) begin
                    ev_low = r_rd_data.score;
                end
                if (r_rd_data.bound == stt_pkg::BND_UPPER
                        && $signed(r_rd_data.score) < $signed(r_cur.hi)) begin
                    ev_high = r_rd_data.score;
                end
                if ($signed(ev_low) >= $signed(ev_high)) begin
                    ev_outcome = stt_pkg::OUT_RETURN;
                    ev_found   = r_rd_data.score;
                end
            end
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            stt_pkg::BK_CLEAR: begin
                if (r_clr_addr == LAST_ADDR) begin
                    n_state = stt_pkg::BK_IDLE;
                end
            end
            stt_pkg::BK_IDLE: begin
                if (o_pop && !i_head.req.is_store) begin
                    n_state = stt_pkg::BK_LOOKUP;
                end
            end
            stt_pkg::BK_LOOKUP: begin
                if (out_free) begin
                    n_state = stt_pkg::BK_IDLE;
                end
            end
            default: begin
                n_state = stt_pkg::BK_IDLE;
            end
        endcase
    end

    always_comb begin
        o_pop         = 1'b0;
        mem_we        = 1'b0;
        mem_waddr     = r_clr_addr;
        mem_wdata     = '0;
        rd_en         = 1'b0;
        out_load      = 1'b0;
        n_out_outcome = stt_pkg::OUT_STORED;
        n_out_found   = '0;
        n_out_low     = '0;
        n_out_high    = '0;
        case (r_state)
            stt_pkg::BK_CLEAR: begin
                mem_we = 1'b1;
            end
            stt_pkg::BK_IDLE: begin
                o_pop = i_head.valid && out_free;
                if (o_pop) begin
                    if (i_head.req.is_store) begin
                        mem_we          = 1'b1;
                        mem_waddr       = i_head.req.index;
                        mem_wdata.tag   = i_head.req.key;
                        mem_wdata.score = i_head.req.score;
                        mem_wdata.depth = i_head.req.depth;
                        mem_wdata.bound = i_head.req.bound;
                        out_load        = 1'b1;
                    end else begin
                        rd_en = 1'b1;
                    end
                end
            end
            stt_pkg::BK_LOOKUP: begin
                out_load      = out_free;
                n_out_outcome = ev_outcome;
                n_out_found   = ev_found;
                n_out_low     = ev_low;
                n_out_high    = ev_high;
            end
            default: begin
                o_pop = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= stt_pkg::BK_CLEAR;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == stt_pkg::BK_CLEAR) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_outcome <= n_out_outcome;
            r_out_found   <= n_out_found;
            r_out_low     <= n_out_low;
            r_out_high    <= n_out_high;
        end
        if (rd_en) begin
            r_cur <= i_head.req;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_table[mem_waddr] <= mem_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_data <= r_table[i_head.req.index];
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_outcome     = r_out_outcome;
    assign o_found_score = r_out_found;
    assign o_new_low     = r_out_low;
    assign o_new_high    = r_out_high;

endmodule

`default_nettype wire

// ----- sv/search_transposition_table.sv -----
// Direct-mapped transposition table, always replace, 4096 entries.
// A store passes the front register, queue and output register; a probe
// also the table read register. Throughput: one store per cycle while the
// output is free; a probe holds the back end as its single table port
// reads, then evaluates the registered entry. Reset (synchronous, active
// low) clears every entry to zero; no item is accepted until that ends.
`timescale 1ns / 1ps
`default_nettype none

module search_transposition_table (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_stall,
    input  wire logic                 i_action,
    input  wire logic [63:0]          i_pos_key,
    input  wire logic [5:0]           i_search_depth,
    input  wire logic signed [31:0]   i_window_low,
    input  wire logic signed [31:0]   i_window_high,
    input  wire logic signed [31:0]   i_store_score,
    input  wire logic [1:0]           i_store_bound,
    output logic                      o_out_valid,
    input  wire logic                 i_out_stall,
    output logic [1:0]                o_outcome,
    output logic signed [31:0]        o_found_score,
    output logic signed [31:0]        o_new_low,
    output logic signed [31:0]        o_new_high
);

    stt_pkg::t_slot push;
    stt_pkg::t_slot head;
    logic           q_full;
    logic           pop;
    logic           clearing;

    stt_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_action       (i_action),
        .i_pos_key      (i_pos_key),
        .i_search_depth (i_search_depth),
        .i_window_low   (i_window_low),
        .i_window_high  (i_window_high),
        .i_store_score  (i_store_score),
        .i_store_bound  (i_store_bound),
        .i_clearing     (clearing),
        .i_q_full       (q_full),
        .o_push         (push)
    );

    stt_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (pop),
        .o_head  (head),
        .o_full  (q_full)
    );

    stt_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_head        (head),
        .o_pop         (pop),
        .o_clearing    (clearing),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_outcome     (o_outcome),
        .o_found_score (o_found_score),
        .o_new_low     (o_new_low),
        .o_new_high    (o_new_high)
    );

endmodule

`default_nettype wire

// ----- tb/sv/stt_checker.sv -----
// Scoreboard for the search transposition table: watches both channels, keeps its own
// copy of the table, predicts every result and compares it field by field.
// Depends on stt_pkg for the table size, bound codes and outcome codes.
`timescale 1ns / 1ps

module stt_checker
    import stt_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_stall,
    input  logic               i_action,
    input  logic [63:0]        i_pos_key,
    input  logic [5:0]         i_search_depth,
    input  logic signed [31:0] i_window_low,
    input  logic signed [31:0] i_window_high,
    input  logic signed [31:0] i_store_score,
    input  logic [1:0]         i_store_bound,
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  logic [1:0]         i_outcome,
    input  logic signed [31:0] i_found_score,
    input  logic signed [31:0] i_new_low,
    input  logic signed [31:0] i_new_high,
    output int                 o_fail_count,
    output int                 o_pending
);

    typedef struct packed {
        t_outcome           outcome;
        logic signed [31:0] found;
        logic signed [31:0] lo;
        logic signed [31:0] hi;
    } t_answer;

    logic [63:0]        tag_mem   [TABLE_ENTRIES];
    logic signed [31:0] score_mem [TABLE_ENTRIES];
    logic [5:0]         depth_mem [TABLE_ENTRIES];
    logic [1:0]         bound_mem [TABLE_ENTRIES];

    t_answer answer_q[$];
    int      fail_count = 0;
    int      pending    = 0;

    assign o_fail_count = fail_count;
    assign o_pending    = pending;

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("MISMATCH %s: got %0d, expected %0d (t=%0t)", what, got, want, $realtime);
        fail_count++;
    endtask

    // Looks the key up in the shadow table and works out the outcome and the window.
    function automatic t_answer probe_answer(input logic [63:0] key, input logic [5:0] need,
                                             input logic signed [31:0] lo_in,
                                             input logic signed [31:0] hi_in);
        t_answer            a;
        logic [IDX_W-1:0]   slot;
        logic signed [31:0] lo;
        logic signed [31:0] hi;
        logic signed [31:0] sc;
        slot      = key[IDX_W-1:0];
        lo        = lo_in;
        hi        = hi_in;
        a.outcome = OUT_CONTINUE;
        a.found   = '0;
        if (tag_mem[slot] == key && depth_mem[slot] >= need) begin
            sc = score_mem[slot];
            if (bound_mem[slot] == BND_EXACT) begin
                a.outcome = OUT_RETURN;
                a.found   = sc;
            end else begin
                if (bound_mem[slot] == BND_LOWER && sc > lo) lo = sc;
                if (bound_mem[slot] == BND_UPPER && sc < hi) hi = sc;
                // The spare bound code narrows nothing; only the window test applies.
                if (lo >= hi) begin
                    a.outcome = OUT_RETURN;
                    a.found   = sc;
                end
            end
        end
        a.lo = lo;
        a.hi = hi;
        return a;
    endfunction

    always @(posedge i_clk) begin : watch
        t_answer          ans;
        t_answer          want;
        logic [IDX_W-1:0] slot;
        if (!i_rst_n) begin
            for (int i = 0; i < TABLE_ENTRIES; i++) begin
                tag_mem[i]   = '0;
                score_mem[i] = '0;
                depth_mem[i] = '0;
                bound_mem[i] = BND_EXACT;
            end
            answer_q.delete();
            pending = 0;
        end else begin
            if (i_in_valid && !i_in_stall) begin
                slot = i_pos_key[IDX_W-1:0];
                if (i_action == ACT_STORE) begin
                    tag_mem[slot]   = i_pos_key;
                    score_mem[slot] = i_store_score;
                    depth_mem[slot] = i_search_depth;
                    bound_mem[slot] = i_store_bound;
                    ans.outcome     = OUT_STORED;
                    ans.found       = '0;
                    ans.lo          = '0;
                    ans.hi          = '0;
                end else begin
                    ans = probe_answer(i_pos_key, i_search_depth, i_window_low, i_window_high);
                end
                answer_q = {answer_q, ans};
            end
            if (i_out_valid && !i_out_stall) begin
                if (answer_q.size() == 0) begin
                    report_mismatch("result with nothing outstanding, outcome",
                                    i_outcome, -1);
                end else begin
                    want = answer_q.pop_front();
                    if (i_outcome !== want.outcome)
                        report_mismatch("outcome", i_outcome, want.outcome);
                    if (i_found_score !== want.found)
                        report_mismatch("found_score", i_found_score, want.found);
                    if (i_new_low !== want.lo)
                        report_mismatch("new_low", i_new_low, want.lo);
                    if (i_new_high !== want.hi)
                        report_mismatch("new_high", i_new_high, want.hi);
                end
            end
            pending = answer_q.size();
        end
    end

endmodule

// ----- tb/sv/tb_search_transposition_table.sv -----
// Top of the transposition table testbench: clock, reset, request traffic and verdict.
// Depends on stt_pkg, search_transposition_table and the stt_checker scoreboard.
`timescale 1ns / 1ps

module tb_search_transposition_table;
    import stt_pkg::*;

    localparam logic       ACT_PROBE   = 1'b0;
    localparam logic [1:0] BND_SPARE   = 2'd3;
    localparam int         MAX_WAIT    = 13;
    localparam int         LONG_HOLD   = 300;
    localparam int         POOL_SIZE   = 16;
    localparam int         SLOT_KINDS  = 6;
    localparam int         CYCLE_LIMIT = 300000;

    logic               clk;
    logic               rst_n        = 1'b0;
    logic               in_valid     = 1'b0;
    logic               in_stall;
    logic               action       = ACT_PROBE;
    logic [63:0]        pos_key      = '0;
    logic [5:0]         search_depth = '0;
    logic signed [31:0] window_low   = '0;
    logic signed [31:0] window_high  = '0;
    logic signed [31:0] store_score  = '0;
    logic [1:0]         store_bound  = BND_EXACT;
    logic               out_valid;
    logic               out_stall    = 1'b1;
    logic [1:0]         outcome;
    logic signed [31:0] found_score;
    logic signed [31:0] new_low;
    logic signed [31:0] new_high;

    int          fail_count;
    int          pending;
    int          tx_max      = 3;
    int          rx_max      = 3;
    bit          rx_hold_req = 1'b0;
    int          cycles      = 0;
    logic [63:0] key_pool [POOL_SIZE];

    search_transposition_table i_dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .o_in_stall     (in_stall),
        .i_action       (action),
        .i_pos_key      (pos_key),
        .i_search_depth (search_depth),
        .i_window_low   (window_low),
        .i_window_high  (window_high),
        .i_store_score  (store_score),
        .i_store_bound  (store_bound),
        .o_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .o_outcome      (outcome),
        .o_found_score  (found_score),
        .o_new_low      (new_low),
        .o_new_high     (new_high)
    );

    stt_checker u_checker (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .i_in_stall     (in_stall),
        .i_action       (action),
        .i_pos_key      (pos_key),
        .i_search_depth (search_depth),
        .i_window_low   (window_low),
        .i_window_high  (window_high),
        .i_store_score  (store_score),
        .i_store_bound  (store_bound),
        .i_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .i_outcome      (outcome),
        .i_found_score  (found_score),
        .i_new_low      (new_low),
        .i_new_high     (new_high),
        .o_fail_count   (fail_count),
        .o_pending      (pending)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Result side: a random stall before each item, or a long hold-off when asked for.
    initial begin : rx_side
        int wait_cycles;
        forever begin
            if (rx_hold_req) begin
                rx_hold_req = 1'b0;
                wait_cycles = LONG_HOLD;
            end else begin
                wait_cycles = $urandom_range(0, rx_max);
            end
            repeat (wait_cycles) begin
                @(negedge clk);
                out_stall <= 1'b1;
            end
            @(negedge clk);
            out_stall <= 1'b0;
            do @(posedge clk); while (!(out_valid && !out_stall));
        end
    end

    // Offers one item after a random gap and returns once the block has taken it.
    task automatic push_request(input logic act, input logic [63:0] key, input logic [5:0] dep,
                                input logic signed [31:0] lo, input logic signed [31:0] hi,
                                input logic signed [31:0] sc, input logic [1:0] bnd);
        int gap;
        gap = $urandom_range(0, tx_max);
        repeat (gap) begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
        @(negedge clk);
        in_valid     <= 1'b1;
        action       <= act;
        pos_key      <= key;
        search_depth <= dep;
        window_low   <= lo;
        window_high  <= hi;
        store_score  <= sc;
        store_bound  <= bnd;
        do @(posedge clk); while (in_stall);
    endtask

    // Withdraws the last item and waits until every expected result has come back.
    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        wait (pending == 0);
    endtask

    task automatic probe(input logic [63:0] key, input logic [5:0] dep,
                         input logic signed [31:0] lo, input logic signed [31:0] hi);
        push_request(ACT_PROBE, key, dep, lo, hi, $urandom, 2'($urandom));
    endtask

    task automatic store(input logic [63:0] key, input logic [5:0] dep,
                         input logic signed [31:0] sc, input logic [1:0] bnd);
        push_request(ACT_STORE, key, dep, $urandom, $urandom, sc, bnd);
    endtask

    // Mostly keys from a small pool that share a few slots, so that stores are found
    // again and also evicted by other tags; the rest are keys from the whole space.
    task automatic random_request();
        logic [63:0]        key;
        logic               act;
        logic [5:0]         dep;
        logic signed [31:0] lo;
        logic signed [31:0] hi;
        logic signed [31:0] sc;
        key = ($urandom_range(0, 9) < 8) ? key_pool[$urandom_range(0, POOL_SIZE - 1)]
                                         : {$urandom, $urandom};
        act = ($urandom_range(0, 9) < 4) ? ACT_STORE : ACT_PROBE;
        if (act == ACT_STORE)
            dep = ($urandom_range(0, 3) == 0) ? 6'($urandom) : 6'($urandom_range(8, 63));
        else
            dep = ($urandom_range(0, 3) == 0) ? 6'($urandom) : 6'($urandom_range(0, 8));
        sc = ($urandom_range(0, 1) == 0) ? int'($urandom_range(0, 400)) - 200 : $urandom;
        if ($urandom_range(0, 9) < 6) begin
            lo = int'($urandom_range(0, 400)) - 200;
            hi = lo + int'($urandom_range(0, 200)) - 30;
        end else begin
            lo = $urandom;
            hi = $urandom;
        end
        push_request(act, key, dep, lo, hi, sc, 2'($urandom));
    endtask

    initial begin : stimulus
        logic [IDX_W-1:0]  slot_set [SLOT_KINDS];
        logic [63:0]       k1;
        logic [63:0]       k2;
        logic [63:0]       k3;
        logic [63:0]       k4;
        logic [63:0]       k5;

        slot_set[0] = '0;
        for (int i = 1; i < SLOT_KINDS; i++) slot_set[i] = IDX_W'($urandom);
        for (int i = 0; i < POOL_SIZE; i++) begin
            key_pool[i]            = {$urandom, $urandom};
            key_pool[i][IDX_W-1:0] = slot_set[i % SLOT_KINDS];
        end
        key_pool[0] = '0;
        k1 = 64'h0123_4567_89AB_C001;
        k2 = 64'hFEDC_BA98_7654_3002;
        k3 = 64'h8000_0000_0000_0003;
        k4 = 64'h5A5A_A5A5_3C3C_C004;
        k5 = 64'h0000_0001_0000_0005;

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Entries never written hold tag zero, depth zero, exact, score zero.
        probe(64'h0, 6'd0, -5, 5);
        probe(64'h0, 6'd1, -5, 5);
        probe(64'h0000_0000_0000_1000, 6'd0, -5, 5);
        probe('1, 6'd63, 32'sh8000_0000, 32'sh7FFF_FFFF);
        // Exact entry at the score and depth extremes.
        store(k1, 6'd63, 32'sh7FFF_FFFF, BND_EXACT);
        probe(k1, 6'd63, 32'sh8000_0000, 32'sh7FFF_FFFF);
        // Lower bound at the most negative score, then too shallow.
        store(k2, 6'd10, 32'sh8000_0000, BND_LOWER);
        probe(k2, 6'd5, 32'sh8000_0000, 32'sh7FFF_FFFF);
        probe(k2, 6'd11, 0, 10);
        // Lower bound raising alpha, first short of beta, then past it.
        store(k3, 6'd20, 50, BND_LOWER);
        probe(k3, 6'd20, 0, 100);
        probe(k3, 6'd3, 0, 40);
        // Upper bound lowering beta.
        store(k4, 6'd7, -20, BND_UPPER);
        probe(k4, 6'd7, -50, 50);
        probe(k4, 6'd0, 0, 50);
        // The spare bound code narrows nothing.
        store(k5, 6'd30, 7, BND_SPARE);
        probe(k5, 6'd30, 10, 10);
        probe(k5, 6'd30, 1, 9);
        // Inverted windows on a hit that is not exact and on a miss.
        probe(k3, 6'd0, 100, -100);
        probe(64'h7777_0000_0000_0ABC, 6'd0, 100, -100);
        // All-ones key and an eviction of the first key by a tag on its slot.
        store('1, 6'd63, 32'sh8000_0000, BND_UPPER);
        probe('1, 6'd63, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
        store(k1 ^ 64'h0000_0000_0001_0000, 6'd63, 1, BND_EXACT);
        probe(k1, 6'd0, -1, 1);
        drain();

        tx_max = MAX_WAIT;
        rx_max = MAX_WAIT;
        repeat (250) random_request();
        drain();

        // Hold results back while items keep coming, so the block fills and stalls.
        tx_max      = 0;
        rx_hold_req = 1'b1;
        repeat (30) random_request();
        drain();

        rx_max = 0;
        repeat (200) random_request();

        tx_max = MAX_WAIT;
        rx_max = 2;
        repeat (180) random_request();
        drain();

        tx_max = 2;
        rx_max = MAX_WAIT;
        repeat (190) random_request();

        drain();
        repeat (20) @(posedge clk);
        if (fail_count == 0 && pending == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
